>>> hdl/tensor_axis_permute_addresser_defines.svh
`ifndef TENSOR_AXIS_PERMUTE_ADDRESSER_DEFINES_SVH
`define TENSOR_AXIS_PERMUTE_ADDRESSER_DEFINES_SVH

// Check a condition at every edge outside reset.
`define TAP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tap: invariant violated");

// Check that a trigger is followed by a consequence in the next cycle.
`define TAP_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("tap: next-cycle check failed");

`endif

>>> hdl/tap_pkg.sv
package tap_pkg;

  localparam int MAX_AXES    = 4;
  localparam int AXIS_W      = 2;
  localparam int INDEX_W     = 8;
  localparam int EXTENT_W    = 9;
  localparam int MAX_EXTENT  = 256;
  localparam int ORDER_W     = 3;
  localparam int PERM_W      = 8;
  localparam int ELEMENT_W   = 64;
  localparam int OFFSET_W    = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_ORDER  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_0 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_1 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_2 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_3 = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_PERM   = 3'd5;

  localparam logic [PERM_W-1:0] PERM_IDENTITY = 8'hE4;

  typedef struct packed {
    logic [ORDER_W-1:0]                   order;
    logic [MAX_AXES-1:0][EXTENT_W-1:0]    size;
    logic [PERM_W-1:0]                    perm;
  } cfg_t;

  typedef struct packed {
    logic [MAX_AXES-1:0][INDEX_W-1:0]     index;
    logic [ELEMENT_W-1:0]                 element;
    logic                                 last;
    logic                                 status;
  } item_t;

  function automatic logic [AXIS_W-1:0] perm_field(input logic [PERM_W-1:0] perm,
                                                   input int k);
    return perm[k*AXIS_W +: AXIS_W];
  endfunction

endpackage

>>> hdl/tap_cfg.sv
module tap_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tap_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tap_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tap_pkg::cfg_t                   cfg
);
  import tap_pkg::*;

  logic [ORDER_W-1:0]  order_val;
  logic [ORDER_W-1:0]  order_sat;
  logic [EXTENT_W-1:0] size_val;
  logic [EXTENT_W-1:0] size_sat;
  logic [AXIS_W-1:0]   size_sel;

  assign order_val = cfg_data[ORDER_W-1:0];
  assign order_sat = (order_val > ORDER_W'(MAX_AXES)) ? ORDER_W'(MAX_AXES) : order_val;
  assign size_val  = cfg_data[EXTENT_W-1:0];
  assign size_sat  = (size_val > EXTENT_W'(MAX_EXTENT)) ? EXTENT_W'(MAX_EXTENT) : size_val;
  assign size_sel  = AXIS_W'(cfg_addr - REG_SIZE_0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.order <= ORDER_W'(1);
      for (int a = 0; a < MAX_AXES; a++) begin
        cfg.size[a] <= EXTENT_W'(1);
      end
      cfg.perm <= PERM_IDENTITY;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_ORDER: begin
          if (order_val != '0) cfg.order <= order_sat;
        end
        REG_SIZE_0, REG_SIZE_1, REG_SIZE_2, REG_SIZE_3: begin
          if (size_val != '0) cfg.size[size_sel] <= size_sat;
        end
        REG_PERM: begin
          cfg.perm <= cfg_data[PERM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/tap_front.sv
`include "tensor_axis_permute_addresser_defines.svh"

module tap_front (
  input  logic                            clk,
  input  logic                            rst,
  input  tap_pkg::cfg_t                   cfg,
  input  logic                            accept,
  input  logic [tap_pkg::ELEMENT_W-1:0]   element_bits,
  input  logic                            restart,
  output tap_pkg::item_t                  item
);
  import tap_pkg::*;

  logic [MAX_AXES-1:0][INDEX_W-1:0] source_index;
  logic [MAX_AXES-1:0][INDEX_W-1:0] eff_index;
  logic [MAX_AXES-1:0][INDEX_W-1:0] source_index_next;
  logic                             perm_ok;
  logic                             at_end;
  logic                             carry;
  logic [AXIS_W-1:0]                field_k;

  assign eff_index = restart ? '0 : source_index;

  always_comb begin
    perm_ok = 1'b1;
    field_k = '0;
    for (int k = 0; k < MAX_AXES; k++) begin
      field_k = perm_field(cfg.perm, k);
      if (ORDER_W'(k) < cfg.order) begin
        if (ORDER_W'(field_k) >= cfg.order) perm_ok = 1'b0;
        for (int j = 0; j < k; j++) begin
          if (perm_field(cfg.perm, j) == field_k) perm_ok = 1'b0;
        end
      end
    end
  end

  always_comb begin
    at_end = 1'b1;
    for (int k = 0; k < MAX_AXES; k++) begin
      if ((ORDER_W'(k) < cfg.order) &&
          ((EXTENT_W'(eff_index[k]) + EXTENT_W'(1)) < cfg.size[k])) begin
        at_end = 1'b0;
      end
    end
  end

  // advance the odometer, last used axis fastest
  always_comb begin
    source_index_next = eff_index;
    carry = 1'b1;
    for (int a = MAX_AXES - 1; a >= 0; a--) begin
      if (carry && (ORDER_W'(a) < cfg.order)) begin
        if ((EXTENT_W'(eff_index[a]) + EXTENT_W'(1)) < cfg.size[a]) begin
          source_index_next[a] = eff_index[a] + INDEX_W'(1);
          carry = 1'b0;
        end else begin
          source_index_next[a] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_index <= '0;
    end else if (accept) begin
      source_index <= perm_ok ? source_index_next : eff_index;
    end
  end

  assign item.index   = eff_index;
  assign item.element = element_bits;
  assign item.last    = perm_ok & at_end;
  assign item.status  = ~perm_ok;

  `TAP_ASSERT_NEXT(a_idle_holds, !accept, $stable(source_index))
  `TAP_ASSERT_NEXT(a_error_holds, accept && !perm_ok && !restart, $stable(source_index))

endmodule

>>> hdl/tap_queue.sv
`include "tensor_axis_permute_addresser_defines.svh"

module tap_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  tap_pkg::item_t  wr_item,
  output logic            full,
  input  logic            rd_en,
  output tap_pkg::item_t  rd_item,
  output logic            empty
);
  import tap_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `TAP_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(QUEUE_DEPTH))
  `TAP_ASSERT_NEXT(a_count_up, do_wr && !do_rd, count == $past(count) + CNT_W'(1))

endmodule

>>> hdl/tap_back.sv
`include "tensor_axis_permute_addresser_defines.svh"

module tap_back (
  input  logic                            clk,
  input  logic                            rst,
  input  tap_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  input  tap_pkg::item_t                  in_item,
  output logic                            in_ready,
  input  logic                            pop,
  output logic                            empty,
  output logic [tap_pkg::OFFSET_W-1:0]    dest_offset,
  output logic [tap_pkg::ELEMENT_W-1:0]   element_out,
  output logic                            last_element,
  output logic                            status
);
  import tap_pkg::*;

  localparam int PROD_W = OFFSET_W + EXTENT_W;

  logic [MAX_AXES-1:0] stage_valid;
  logic [MAX_AXES-1:0] stage_ready;
  item_t               stage_item [MAX_AXES];
  logic [OFFSET_W-1:0] stage_acc  [MAX_AXES];

  // Horner step per destination axis: acc = acc * extent + index
  for (genvar s = 0; s < MAX_AXES; s++) begin : g_stage
    localparam logic [ORDER_W-1:0] STAGE = ORDER_W'(s);

    logic                prev_valid;
    item_t               prev_item;
    logic [OFFSET_W-1:0] prev_acc;
    logic                down_ready;
    logic [AXIS_W-1:0]   src;
    logic [PROD_W-1:0]   prod;
    logic [OFFSET_W-1:0] acc_next;

    if (s == 0) begin : g_head
      assign prev_valid = in_valid;
      assign prev_item  = in_item;
      assign prev_acc   = '0;
    end else begin : g_body
      assign prev_valid = stage_valid[s-1];
      assign prev_item  = stage_item[s-1];
      assign prev_acc   = stage_acc[s-1];
    end

    if (s == MAX_AXES - 1) begin : g_tail
      assign down_ready = pop;
    end else begin : g_mid
      assign down_ready = stage_ready[s+1];
    end

    assign stage_ready[s] = !stage_valid[s] || down_ready;
    assign src            = perm_field(cfg.perm, s);
    assign prod           = PROD_W'(prev_acc) * PROD_W'(cfg.size[src]);
    assign acc_next       = (STAGE < cfg.order)
                          ? prod[OFFSET_W-1:0] + OFFSET_W'(prev_item.index[src])
                          : prev_acc;

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[s] <= 1'b0;
      end else if (stage_ready[s]) begin
        stage_valid[s] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (stage_ready[s] && prev_valid) begin
        stage_item[s] <= prev_item;
        stage_acc[s]  <= acc_next;
      end
    end
  end

  assign in_ready     = stage_ready[0];
  assign empty        = !stage_valid[MAX_AXES-1];
  assign status       = stage_item[MAX_AXES-1].status;
  assign last_element = stage_item[MAX_AXES-1].last;
  assign element_out  = stage_item[MAX_AXES-1].element;
  assign dest_offset  = status ? '0 : stage_acc[MAX_AXES-1];

  `TAP_ASSERT_ALWAYS(a_error_not_last, empty || !status || !last_element)

endmodule

>>> hdl/tensor_axis_permute_addresser.sv
// Tensor axis permutation addresser.
// Input channel (push/full): one beat per source element in row-major order,
// carrying element_bits and restart; a beat is taken when push is high and
// full is low. restart clears the source index before that element.
// Result channel (empty/pop): one beat per input beat, in order, carrying
// dest_offset, element_out, last_element and status; the oldest result is
// shown while empty is low and leaves when pop is high.
// Configuration: cfg_write with cfg_addr/cfg_data writes one register
// (order, four extents, permutation); write only while no beat is in flight.
// An accepted beat is written into the queue, then passes the offset pipeline
// (a multiply per axis); throughput is one beat per cycle while pop is high.
// When pop is held low the pipeline and a two-beat queue fill up, then full
// rises; nothing is dropped. Reset clears the source index, empties the
// pipeline and loads order 1, extents 1 and the identity permutation.
module tensor_axis_permute_addresser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tap_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tap_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [tap_pkg::ELEMENT_W-1:0]   element_bits,
  input  logic                            restart,
  output logic                            empty,
  input  logic                            pop,
  output logic [tap_pkg::OFFSET_W-1:0]    dest_offset,
  output logic [tap_pkg::ELEMENT_W-1:0]   element_out,
  output logic                            last_element,
  output logic                            status
);
  import tap_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  item_t queue_item;
  logic  accept;
  logic  queue_empty;
  logic  back_ready;

  assign accept = push && !full;

  tap_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tap_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .element_bits (element_bits),
    .restart      (restart),
    .item         (front_item)
  );

  tap_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_item (front_item),
    .full    (full),
    .rd_en   (back_ready),
    .rd_item (queue_item),
    .empty   (queue_empty)
  );

  tap_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (!queue_empty),
    .in_item      (queue_item),
    .in_ready     (back_ready),
    .pop          (pop),
    .empty        (empty),
    .dest_offset  (dest_offset),
    .element_out  (element_out),
    .last_element (last_element),
    .status       (status)
  );

endmodule
